// File: design/statement_splitter_comment_stripper_assert.svh
`ifndef STATEMENT_SPLITTER_COMMENT_STRIPPER_ASSERT_SVH
`define STATEMENT_SPLITTER_COMMENT_STRIPPER_ASSERT_SVH

// A property that must hold in every cycle outside reset.
`define SSCS_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("statement splitter check failed");

// A condition that must be followed by a consequence in the next cycle.
`define SSCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("statement splitter sequence check failed");

`endif

// File: design/sscs_pkg.sv
package sscs_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_char;
      logic [15:0] position;
      logic [15:0] length;
      logic [2:0]  error_flags;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_SKIP  = 4'd0,
      MODE_MAIN  = 4'd1,
      MODE_SLASH = 4'd2,
      MODE_LINE  = 4'd3,
      MODE_BLOCK = 4'd4,
      MODE_STAR  = 4'd5,
      MODE_ESC   = 4'd6,
      MODE_STR   = 4'd7,
      MODE_PURGE = 4'd8
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  quote;
      logic [15:0] count;
      logic        ctrl;
      logic        last_blank;
      logic [2:0]  flags;
   } stmt_state_type;

   typedef struct packed {
      stmt_state_type st;
      logic           ok;
   } acc_type;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_EOF  = 2'd2;
   localparam logic [1:0] KIND_RSVD = 2'd3;

   localparam logic [2:0] FLAG_OVF    = 3'b001;
   localparam logic [2:0] FLAG_SYNTAX = 3'b010;
   localparam logic [2:0] FLAG_STRING = 3'b100;

   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   localparam stmt_state_type ST_RESET = '{MODE_SKIP, 8'd0, 16'd0, 1'b0, 1'b0, 3'd0};

   function automatic acc_type accept_fn(stmt_state_type s, logic [7:0] c,
                                         logic [15:0] max_len);
      acc_type r;
      r.st = s;
      r.ok = 1'b0;
      if (({1'b0, s.count} + 17'd1) >= {1'b0, max_len}) begin
         r.st.mode  = MODE_PURGE;
         r.st.flags = s.flags | FLAG_OVF;
      end else begin
         r.ok = 1'b1;
         if (s.count == 16'd0) begin
            r.st.ctrl = (c == CH_HASH);
         end
         r.st.last_blank = (c == CH_SPACE);
         r.st.count      = s.count + 16'd1;
      end
      return r;
   endfunction

   function automatic rsp_type char_rec(logic [7:0] c, logic [15:0] pos);
      return '{KIND_CHAR, c, pos, 16'd0, 3'd0};
   endfunction

   function automatic rsp_type end_rec(logic [15:0] len, logic [2:0] fl);
      return '{KIND_END, 8'd0, 16'd0, len, fl};
   endfunction

   function automatic rsp_type eof_rec();
      return '{KIND_EOF, 8'd0, 16'd0, 16'd0, 3'd0};
   endfunction

endpackage

// File: design/statement_splitter_comment_stripper.sv
// Statement splitter and comment stripper.
// The req channel takes one source byte, or an end-of-file mark, per transaction.
// The rsp channel returns statement characters with their index, statement-end
// records with length and error flags, and an end-of-input record.
// The csr port writes the buffer size register; write it only while idle.
// An accepted byte is registered in the input register and processed from there
// once the result register is empty or is handing over its last entry; its
// results are registered in the result register and offered from it.
// A byte causes zero to three results, held in a three-entry result register
// that drains one transaction per cycle while rsp_stall is low; the next byte
// is processed in the cycle the last of them leaves, so one byte per cycle is
// sustained whenever each byte yields at most one result and rsp_stall is low.
// When the receiver stalls, the result register holds, the input register
// fills, and then req_stall rises.
// Synchronous reset empties both registers, returns the parser to skipping
// leading blanks, and sets the buffer size to 256.
module statement_splitter_comment_stripper (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sscs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sscs_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [15:0]      csr_wdata
);
   import sscs_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type        in_ff;
   stmt_state_type st_ff, st_in;
   logic [15:0]    len_ff;
   rsp_type        res_ff [3];
   rsp_type        res_in [3];
   logic [1:0]     rem_ff, rem_in;
   logic           rsp_fire, process, req_fire;
   acc_type        acc;
   logic           main_go, tail_go;
   logic [7:0]     c;

   assign rsp_valid = (rem_ff != 2'd0);
   assign rsp_data  = res_ff[0];
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign process   = in_valid_ff &&
                      ((rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_fire));
   assign req_stall = in_valid_ff && !process;
   assign req_fire  = req_valid && !req_stall;
   assign c         = in_ff.ch;

   always_comb begin
      st_in   = st_ff;
      rem_in  = 2'd0;
      res_in  = '{default: '0};
      acc     = '0;
      main_go = 1'b0;
      tail_go = 1'b0;
      if (in_ff.end_of_file) begin
         if (st_in.mode == MODE_SLASH) begin
            acc = accept_fn(st_in, CH_SLASH, len_ff);
            if (acc.ok) begin
               res_in[rem_in] = char_rec(CH_SLASH, st_in.count);
               rem_in = rem_in + 2'd1;
            end
            st_in = acc.st;
         end else if (st_in.mode == MODE_ESC) begin
            st_in.flags = st_in.flags | FLAG_SYNTAX;
         end else if (st_in.mode == MODE_STR) begin
            st_in.flags = st_in.flags | FLAG_STRING;
         end
         if (st_in.mode == MODE_PURGE) begin
            res_in[rem_in] = end_rec(16'd0, st_in.flags | FLAG_OVF);
            rem_in = rem_in + 2'd1;
         end else if (st_in.count != 16'd0) begin
            res_in[rem_in] = end_rec(st_in.count, st_in.flags);
            rem_in = rem_in + 2'd1;
         end
         res_in[rem_in] = eof_rec();
         rem_in = rem_in + 2'd1;
         st_in = ST_RESET;
      end else begin
         unique case (st_in.mode)
            MODE_SKIP: begin
               if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
                  st_in.mode = MODE_MAIN;
                  main_go = 1'b1;
               end
            end
            MODE_MAIN: begin
               main_go = 1'b1;
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  st_in.mode = MODE_LINE;
               end else if (c == CH_STAR) begin
                  st_in.mode = MODE_BLOCK;
               end else begin
                  acc = accept_fn(st_in, CH_SLASH, len_ff);
                  if (acc.ok) begin
                     res_in[rem_in] = char_rec(CH_SLASH, st_in.count);
                     rem_in = rem_in + 2'd1;
                  end
                  st_in = acc.st;
                  tail_go = acc.ok;
               end
            end
            MODE_LINE: begin
               if (c == CH_LF) begin
                  if (st_in.ctrl) begin
                     res_in[rem_in] = end_rec(st_in.count, st_in.flags);
                     rem_in = rem_in + 2'd1;
                     st_in = ST_RESET;
                  end else begin
                     st_in.mode = MODE_MAIN;
                  end
               end
            end
            MODE_BLOCK: begin
               if (c == CH_STAR) begin
                  st_in.mode = MODE_STAR;
               end
            end
            MODE_STAR: begin
               if (c == CH_SLASH) begin
                  st_in.mode = MODE_MAIN;
               end else if (c != CH_STAR) begin
                  st_in.mode = MODE_BLOCK;
               end
            end
            MODE_ESC: begin
               if (c == CH_LF || c == CH_CR) begin
                  res_in[rem_in] = end_rec(st_in.count, st_in.flags | FLAG_SYNTAX);
                  rem_in = rem_in + 2'd1;
                  st_in = ST_RESET;
               end else begin
                  acc = accept_fn(st_in, c, len_ff);
                  if (acc.ok) begin
                     res_in[rem_in] = char_rec(c, st_in.count);
                     rem_in = rem_in + 2'd1;
                  end
                  st_in = acc.st;
                  if (acc.ok) begin
                     st_in.mode = MODE_MAIN;
                  end
               end
            end
            MODE_STR: begin
               if (c == CH_LF || c == CH_CR) begin
                  st_in.flags = st_in.flags | FLAG_STRING;
                  if (st_in.ctrl) begin
                     res_in[rem_in] = end_rec(st_in.count, st_in.flags | FLAG_SYNTAX);
                     rem_in = rem_in + 2'd1;
                     st_in = ST_RESET;
                  end
               end else begin
                  acc = accept_fn(st_in, c, len_ff);
                  if (acc.ok) begin
                     res_in[rem_in] = char_rec(c, st_in.count);
                     rem_in = rem_in + 2'd1;
                  end
                  st_in = acc.st;
                  if (acc.ok && (c == st_in.quote)) begin
                     st_in.mode = MODE_MAIN;
                  end
               end
            end
            MODE_PURGE: begin
               if (c == CH_SEMI) begin
                  res_in[rem_in] = end_rec(16'd0, st_in.flags | FLAG_OVF);
                  rem_in = rem_in + 2'd1;
                  st_in = ST_RESET;
               end
            end
            default: begin
               st_in = ST_RESET;
            end
         endcase

         if (main_go) begin
            priority if (c == CH_SPACE) begin
               if ((st_in.count == 16'd0) || st_in.last_blank) begin
                  st_in.mode = MODE_SKIP;
               end else begin
                  tail_go = 1'b1;
               end
            end else if (c == CH_LF) begin
               if ((st_in.count != 16'd0) && st_in.ctrl) begin
                  res_in[rem_in] = end_rec(st_in.count, st_in.flags);
                  rem_in = rem_in + 2'd1;
                  st_in = ST_RESET;
               end
            end else if (c == CH_CR) begin
               st_in.mode = MODE_MAIN;
            end else if (c == CH_SLASH) begin
               st_in.mode = MODE_SLASH;
            end else begin
               tail_go = 1'b1;
            end
         end

         if (tail_go) begin
            acc = accept_fn(st_in, c, len_ff);
            if (acc.ok) begin
               res_in[rem_in] = char_rec(c, st_in.count);
               rem_in = rem_in + 2'd1;
            end
            st_in = acc.st;
            if (acc.ok) begin
               st_in.mode = MODE_MAIN;
               priority if (c == CH_SEMI) begin
                  res_in[rem_in] = end_rec(st_in.count, st_in.flags);
                  rem_in = rem_in + 2'd1;
                  st_in = ST_RESET;
               end else if (c == CH_BSLASH) begin
                  st_in.mode = MODE_ESC;
               end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                  st_in.quote = c;
                  st_in.mode  = MODE_STR;
               end else begin
                  st_in.mode = MODE_MAIN;
               end
            end
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= ST_RESET;
         len_ff      <= MAX_LENGTH_RESET;
         rem_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write) begin
            len_ff <= csr_wdata;
         end
         if (process) begin
            st_ff  <= st_in;
            rem_ff <= rem_in;
         end else if (rsp_fire) begin
            rem_ff <= rem_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_data;
      end
      if (process) begin
         res_ff <= res_in;
      end else if (rsp_fire) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
      end
   end

`include "statement_splitter_comment_stripper_assert.svh"

   `SSCS_ASSERT_ALWAYS(a_no_reserved_kind, clock, reset,
      !rsp_valid || (rsp_data.kind != KIND_RSVD))
   `SSCS_ASSERT_ALWAYS(a_char_has_no_end_fields, clock, reset,
      !(rsp_valid && (rsp_data.kind == KIND_CHAR)) ||
      ((rsp_data.length == 16'd0) && (rsp_data.error_flags == 3'd0)))
   `SSCS_ASSERT_ALWAYS(a_stall_only_when_held, clock, reset,
      !req_stall || (in_valid_ff && (rem_ff != 2'd0)))
   `SSCS_ASSERT_NEXT(a_eof_clears_state, clock, reset, process && in_ff.end_of_file,
      (st_ff == ST_RESET) && (rem_ff != 2'd0))

endmodule
